// ===== rtl/complex_gain_imbalance_estimator_macros.svh =====
// Assertion macros for the complex gain imbalance estimator.
// Used by the controller and datapath modules; no other dependencies.
`ifndef COMPLEX_GAIN_IMBALANCE_ESTIMATOR_MACROS_SVH
`define COMPLEX_GAIN_IMBALANCE_ESTIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CGIE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CGIE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CGIE_ASSERT(label, clk, rst_n, prop, msg)
`define CGIE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/cgie_pkg.sv =====
// Shared types and constants for the complex gain imbalance estimator.
// No dependencies.
package cgie_pkg;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned FRAC_BITS = 15;

  localparam logic [0:0] REG_IS_SOURCE = 1'b0;
  localparam logic [0:0] REG_IS_END    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture input beat
    logic div_start; // start divider
    logic div_sel;   // 0: real numerator, 1: imaginary
    logic acc;       // add terms, update counters
    logic out_load;  // fill output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;
endpackage

// ===== rtl/cgie_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, saturating term.
// Depends on cgie_pkg.
module cgie_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [cgie_pkg::NUM_W-1:0] num,
  input  logic [cgie_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic signed [31:0]            term
);
  localparam int unsigned QW = cgie_pkg::NUM_W + cgie_pkg::FRAC_BITS;

  logic [QW-1:0] q_r, q_nxt;
  logic [cgie_pkg::DEN_W:0] rem_r, rem_nxt;
  logic [cgie_pkg::DEN_W-1:0] den_r;
  logic neg_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [cgie_pkg::NUM_W-1:0] mag;
  logic [cgie_pkg::DEN_W:0] shl;
  logic [QW-1:0] q_sat;

  assign mag = num[cgie_pkg::NUM_W-1] ? cgie_pkg::NUM_W'(-num) : cgie_pkg::NUM_W'(num);

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    shl = {rem_r[cgie_pkg::DEN_W-1:0], q_r[QW-1]};
    if (start) begin
      q_nxt = {mag, {cgie_pkg::FRAC_BITS{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = 6'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shl >= {1'b0, den_r}) begin
        rem_nxt = shl - {1'b0, den_r};
        q_nxt = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[cgie_pkg::NUM_W-1];
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);

  always_comb begin
    q_sat = q_r; // final value is in q_r in the cycle after done; term uses q_r then
    if (!neg_r) term = (q_sat > QW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(q_sat);
    else term = (q_sat > QW'(32'h80000000)) ? 32'sh80000000 : -$signed(32'(q_sat));
  end
endmodule

// ===== rtl/cgie_ctrl.sv =====
// Controller FSM: sequences capture, two divisions, accumulate and output.
// Depends on cgie_pkg and the assertion macro header.
`include "complex_gain_imbalance_estimator_macros.svh"
module cgie_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_full,
  input  logic             out_take,
  input  cgie_pkg::sts_t   sts,
  output cgie_pkg::cmd_t   cmd
);
  cgie_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cgie_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      cgie_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = cgie_pkg::ST_MUL;
        end
      end
      cgie_pkg::ST_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt = cgie_pkg::ST_DIV_RE;
      end
      cgie_pkg::ST_DIV_RE: begin
        if (sts.div_done) state_nxt = cgie_pkg::ST_DIV_IM;
      end
      cgie_pkg::ST_DIV_IM: begin
        cmd.div_sel = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = cgie_pkg::ST_ACC;
      end
      cgie_pkg::ST_ACC: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) state_nxt = cgie_pkg::ST_OUT;
      end
      cgie_pkg::ST_OUT: begin
        if (!out_full || out_take) begin
          cmd.acc = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = cgie_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cgie_pkg::ST_IDLE;
    endcase
  end

  `CGIE_ASSERT(a_load_idle, clk, rst_n, cmd.load |-> state_r == cgie_pkg::ST_IDLE, "load outside idle")
  `CGIE_ASSERT(a_load_mul, clk, rst_n, cmd.load |=> state_r == cgie_pkg::ST_MUL, "no multiply after load")
  `CGIE_ASSERT(a_out_room, clk, rst_n, cmd.out_load |-> (!out_full || out_take), "output overrun")
endmodule

// ===== rtl/cgie_dp.sv =====
// Datapath: products, shared divider, saturating accumulators, mean, output.
// Depends on cgie_pkg, cgie_div and the assertion macro header.
`include "complex_gain_imbalance_estimator_macros.svh"
module cgie_dp #(
  parameter int unsigned AVG_COUNT = 16,
  parameter int unsigned FREQ_BINS = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cgie_pkg::cmd_t cmd,
  output cgie_pkg::sts_t sts,
  input  logic [63:0]    in_data,
  input  logic           cfg_src,
  input  logic           cfg_end,
  input  logic           out_take,
  output logic           out_full,
  output logic [79:0]    out_data
);
  localparam int unsigned SW = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
  localparam int unsigned CW = $clog2(AVG_COUNT + 1);
  localparam int unsigned BW = $clog2(FREQ_BINS);
  localparam int unsigned SH = $clog2(AVG_COUNT);
  localparam bit POW2 = (AVG_COUNT == (1 << SH));
  localparam logic signed [cgie_pkg::ACC_W-1:0] AMAX = {1'b0, {(cgie_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [cgie_pkg::ACC_W-1:0] AMIN = {1'b1, {(cgie_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [cgie_pkg::ACC_W-1:0] SMAX = cgie_pkg::ACC_W'((1 << (SW - 1)) - 1);
  localparam logic signed [cgie_pkg::ACC_W-1:0] SMIN = -SMAX - 1;
  // non power of two mean: clamp limits, then reciprocal multiply of the
  // offset accumulator (below 2^XW), exact for that range
  localparam logic signed [cgie_pkg::ACC_W-1:0] NDIV = $signed(cgie_pkg::ACC_W'(AVG_COUNT));
  localparam logic signed [cgie_pkg::ACC_W-1:0] LO_LIM = SMIN * NDIV;
  localparam logic signed [cgie_pkg::ACC_W-1:0] HI_LIM = (SMAX + cgie_pkg::ACC_W'(1)) * NDIV;
  localparam int unsigned XW = SW + SH;
  localparam int unsigned RL = XW + SH;
  localparam logic [XW:0] RM = (XW+1)'(((64'd1 << RL) / 64'(AVG_COUNT)) + 64'd1);

  logic signed [15:0] lr, li, ur, ui;
  logic signed [15:0] lr_r, li_r, ur_r, ui_r;
  logic signed [cgie_pkg::NUM_W-1:0] nim_r;
  logic [cgie_pkg::DEN_W-1:0] den_r;
  logic signed [31:0] tre_r, term;
  logic div_done;
  logic [CW-1:0] cnt_r;
  logic [BW-1:0] bin_r;
  logic zs_r;
  logic signed [cgie_pkg::ACC_W-1:0] are_r, aim_r;
  logic signed [cgie_pkg::ACC_W+1:0] sre, sim;
  logic signed [cgie_pkg::ACC_W-1:0] are_n, aim_n, mre, mim;
  logic last;
  logic [79:0] od_r, od_nxt;
  logic full_r;

  function automatic logic signed [15:0] sx(input logic [15:0] v);
    logic [15:0] s;
    s = v << (16 - SW);
    return $signed(s) >>> (16 - SW);
  endfunction

  function automatic logic signed [cgie_pkg::ACC_W-1:0] mean(
      input logic signed [cgie_pkg::ACC_W-1:0] a);
    logic signed [cgie_pkg::ACC_W-1:0] q;
    logic signed [cgie_pkg::ACC_W-1:0] d;
    logic [2*XW:0] pr;
    d = '0;
    pr = '0;
    if (POW2) q = a >>> SH;
    else begin
      if (a >= HI_LIM) q = SMAX;
      else if (a < LO_LIM) q = SMIN;
      else begin
        d = a - LO_LIM;
        pr = {{(XW+1){1'b0}}, d[XW-1:0]} * {{XW{1'b0}}, RM};
        q = SMIN + cgie_pkg::ACC_W'(pr >> RL);
      end
    end
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    return q;
  endfunction

  assign lr = sx(in_data[15:0]);
  assign li = sx(in_data[31:16]);
  assign ur = sx(in_data[47:32]);
  assign ui = sx(in_data[63:48]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lr_r <= lr; li_r <= li; ur_r <= ur; ui_r <= ui;
    end
    if (cmd.div_start && !cmd.div_sel) begin
      nim_r <= cgie_pkg::NUM_W'(32'(ui_r * lr_r)) - cgie_pkg::NUM_W'(32'(ur_r * li_r));
      den_r <= cgie_pkg::DEN_W'(32'(lr_r * lr_r)) + cgie_pkg::DEN_W'(32'(li_r * li_r));
    end
    if (cmd.div_start && cmd.div_sel) tre_r <= term;
  end

  // products are formed combinationally into the divider on its first start
  logic signed [cgie_pkg::NUM_W-1:0] div_num;
  logic [cgie_pkg::DEN_W-1:0] div_den;
  assign div_num = cmd.div_sel ? nim_r :
                   (cgie_pkg::NUM_W'($signed(32'(ur_r * lr_r))) +
                    cgie_pkg::NUM_W'($signed(32'(ui_r * li_r))));
  assign div_den = (cgie_pkg::DEN_W'(32'(lr_r * lr_r)) + cgie_pkg::DEN_W'(32'(li_r * li_r)));

  cgie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(div_num), .den(cmd.div_sel ? den_r : div_den),
    .done(div_done), .term(term)
  );
  assign sts.div_done = div_done;

  // term of the imaginary division is read at acc time (divider finished)
  assign sre = {{2{are_r[cgie_pkg::ACC_W-1]}}, are_r} + (cgie_pkg::ACC_W+2)'(tre_r);
  assign sim = {{2{aim_r[cgie_pkg::ACC_W-1]}}, aim_r} + (cgie_pkg::ACC_W+2)'(term);
  always_comb begin
    are_n = are_r;
    aim_n = aim_r;
    if (!cfg_src && den_r != '0) begin
      are_n = (sre > AMAX) ? AMAX : (sre < AMIN) ? AMIN : cgie_pkg::ACC_W'(sre);
      aim_n = (sim > AMAX) ? AMAX : (sim < AMIN) ? AMIN : cgie_pkg::ACC_W'(sim);
    end
  end
  assign last = (cnt_r + CW'(1)) >= CW'(AVG_COUNT);
  assign mre = mean(are_n);
  assign mim = mean(aim_n);

  always_comb begin
    od_nxt = '0;
    if (!cfg_end) begin
      od_nxt[15:0]  = cfg_src ? lr_r : ur_r;
      od_nxt[31:16] = cfg_src ? li_r : ui_r;
      od_nxt[32]    = 1'b1;
    end
    if (last) begin
      if (!cfg_src) begin
        od_nxt[48:33] = 16'(mre);
        od_nxt[64:49] = 16'(mim);
      end
      od_nxt[65] = 1'b1;
      od_nxt[75:66] = 10'(bin_r);
      od_nxt[76] = zs_r | (!cfg_src && den_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; bin_r <= '0; zs_r <= 1'b0; are_r <= '0; aim_r <= '0;
      full_r <= 1'b0;
    end else begin
      if (cmd.out_load) full_r <= 1'b1;
      else if (out_take) full_r <= 1'b0;
      if (cmd.acc) begin
        if (last) begin
          cnt_r <= '0; are_r <= '0; aim_r <= '0; zs_r <= 1'b0;
          bin_r <= (bin_r == BW'(FREQ_BINS - 1)) ? '0 : bin_r + BW'(1);
        end else begin
          cnt_r <= cnt_r + CW'(1);
          are_r <= are_n; aim_r <= aim_n;
          if (!cfg_src && den_r == '0) zs_r <= 1'b1;
        end
      end
    end
    if (cmd.out_load) od_r <= od_nxt;
  end
  assign out_full = full_r;
  assign out_data = od_r;

  `CGIE_ASSERT(a_cnt_range, clk, rst_n, cnt_r < CW'(AVG_COUNT), "pair count out of range")
  `CGIE_ASSERT(a_bin_range, clk, rst_n, bin_r <= BW'(FREQ_BINS - 1), "bin out of range")
  `CGIE_ASSERT(a_acc_with_out, clk, rst_n, cmd.acc |-> cmd.out_load, "acc without output")
endmodule

// ===== rtl/complex_gain_imbalance_estimator.sv =====
// Top level of the complex gain imbalance estimator.
// Depends on cgie_pkg, cgie_ctrl, cgie_dp (with cgie_div).
//
// One input beat carries a local and an upstream complex sample; each beat
// yields exactly one output beat, with the forwarded sample unless the end
// flag is set, and on the last pair of each averaging block the mean
// imbalance (zero on a source node), its bin and the zero divisor flag.
// Items are taken one at a time: a beat goes from acceptance to the next
// acceptance through the shared bit-serial divider (48 quotient bits for
// each of the real and imaginary terms) and four control steps (accept,
// start, restart, output load). The output register lets the next beat be
// accepted while a result waits; a result still waiting when the next one
// is ready stalls the block until it is taken.
module complex_gain_imbalance_estimator #(
  parameter int unsigned AVG_COUNT = 16,
  parameter int unsigned FREQ_BINS = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [0:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,  // local_re, local_im, up_re, up_im
  output logic         out_tvalid,
  input  logic         out_tready,
  // fwd_re, fwd_im, fwd_valid, imb_re, imb_im, imb_valid, imb_index,
  // zero_divisor, zero fill
  output logic [79:0]  out_tdata
);
  logic src_r, end_r;
  cgie_pkg::cmd_t cmd;
  cgie_pkg::sts_t sts;
  logic full, take;
  logic [79:0] od;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= 1'b0; end_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgie_pkg::REG_IS_SOURCE: src_r <= cfg_data[0];
        cgie_pkg::REG_IS_END:    end_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign take = out_tvalid && out_tready;

  cgie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_full(full), .out_take(take), .sts(sts), .cmd(cmd)
  );

  cgie_dp #(.AVG_COUNT(AVG_COUNT), .FREQ_BINS(FREQ_BINS),
            .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_tdata),
    .cfg_src(src_r), .cfg_end(end_r), .out_take(take), .out_full(full),
    .out_data(od)
  );

  assign out_tvalid = full;
  assign out_tdata = od;
endmodule
